// ===== rtl/core/lpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_pkg: shared types and constants of the line pixel rasterizer
// Item layouts for the command and pixel channels, register codes, widths.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int COORD_W = 12;           // signed coordinate width
  localparam int ADDR_W  = 22;           // framebuffer address width
  localparam int REG_W   = 12;           // frame size register width
  localparam int ERR_W   = COORD_W + 2;  // Bresenham error term

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // command codes
  localparam logic ACT_LINE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] FRAME_WIDTH_RST  = REG_W'(1280);
  localparam logic [REG_W-1:0] FRAME_HEIGHT_RST = REG_W'(720);

  typedef struct packed {
    logic                      action;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } lpr_cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] pixel_x;
    logic signed [COORD_W-1:0] pixel_y;
    logic                      in_frame;
    logic [ADDR_W-1:0]         pixel_address;
    logic                      last_pixel;
  } lpr_pix_t;

  // current cursor as seen by the address pipeline
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } lpr_cursor_t;

endpackage
`default_nettype wire

// ===== rtl/core/lpr_stepper.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_stepper: Bresenham line state
// Loads endpoints on a line command and advances one step per emitted pixel.
// ----------------------------------------------------------------------------
module lpr_stepper (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                step,
  input  lpr_pkg::lpr_cmd_t   cmd,
  output logic                active,
  output lpr_pkg::lpr_cursor_t cur
);
  import lpr_pkg::*;

  localparam int DIFF_W = COORD_W + 1;
  localparam int E2_W   = ERR_W + 1;

  logic                      line_active;
  logic signed [COORD_W-1:0] cursor_x, cursor_y;
  logic signed [COORD_W-1:0] target_x, target_y;
  logic [COORD_W-1:0]        span_x, span_y;
  logic                      dir_x_negative, dir_y_negative;
  logic signed [ERR_W-1:0]   error_term;

  logic signed [DIFF_W-1:0]  diff_x, diff_y;
  logic [COORD_W-1:0]        span_x_next, span_y_next;
  logic signed [ERR_W-1:0]   sx_e, sy_e, sxn_e, syn_e;
  logic signed [E2_W-1:0]    e2, sx_e2, sy_e2;
  logic                      take_x, take_y, at_end;
  logic signed [ERR_W-1:0]   error_term_next;
  logic signed [COORD_W-1:0] cursor_x_next, cursor_y_next, inc_x, inc_y;

  // line setup
  always_comb begin
    diff_x      = DIFF_W'(cmd.end_x) - DIFF_W'(cmd.start_x);
    diff_y      = DIFF_W'(cmd.end_y) - DIFF_W'(cmd.start_y);
    span_x_next = diff_x[DIFF_W-1] ? COORD_W'(-diff_x) : COORD_W'(diff_x);
    span_y_next = diff_y[DIFF_W-1] ? COORD_W'(-diff_y) : COORD_W'(diff_y);
    sxn_e       = ERR_W'(signed'({1'b0, span_x_next}));
    syn_e       = ERR_W'(signed'({1'b0, span_y_next}));
  end

  // one Bresenham step
  always_comb begin
    at_end  = (cursor_x == target_x) && (cursor_y == target_y);
    sx_e    = ERR_W'(signed'({1'b0, span_x}));
    sy_e    = ERR_W'(signed'({1'b0, span_y}));
    e2      = {error_term, 1'b0};
    sx_e2   = E2_W'(sx_e);
    sy_e2   = E2_W'(sy_e);
    take_x  = e2 > -sy_e2;
    take_y  = e2 < sx_e2;
    error_term_next = error_term - (take_x ? sy_e : '0) + (take_y ? sx_e : '0);
    inc_x   = dir_x_negative ? '1 : COORD_W'(1);
    inc_y   = dir_y_negative ? '1 : COORD_W'(1);
    cursor_x_next = take_x ? cursor_x + inc_x : cursor_x;
    cursor_y_next = take_y ? cursor_y + inc_y : cursor_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (load) begin
      line_active <= 1'b1;
    end else if (step && line_active && at_end) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cursor_x       <= cmd.start_x;
      cursor_y       <= cmd.start_y;
      target_x       <= cmd.end_x;
      target_y       <= cmd.end_y;
      span_x         <= span_x_next;
      span_y         <= span_y_next;
      dir_x_negative <= diff_x[DIFF_W-1] || (diff_x == '0);
      dir_y_negative <= diff_y[DIFF_W-1] || (diff_y == '0);
      error_term     <= sxn_e - syn_e;
    end else if (step && line_active && !at_end) begin
      cursor_x   <= cursor_x_next;
      cursor_y   <= cursor_y_next;
      error_term <= error_term_next;
    end
  end

  assign active = line_active;
  assign cur    = '{x: cursor_x, y: cursor_y, last: at_end};

endmodule
`default_nettype wire

// ===== rtl/core/lpr_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lpr_pipe: bounds check and framebuffer address
// Stage 1 registers bounds flag and flipped row, stage 2 the address product.
// ----------------------------------------------------------------------------
module lpr_pipe (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lpr_pkg::lpr_cursor_t cur,
  input  logic [lpr_pkg::REG_W-1:0] frame_width,
  input  logic [lpr_pkg::REG_W-1:0] frame_height,
  input  logic                 pix_stall,
  output logic                 hold,
  output logic                 pix_valid,
  output lpr_pkg::lpr_pix_t    pix
);
  import lpr_pkg::*;

  localparam int CMP_W = (COORD_W > REG_W) ? COORD_W : REG_W;
  localparam int SUM_W = 2 * REG_W + 1;

  logic                      s1_valid;
  logic signed [COORD_W-1:0] s1_x, s1_y;
  logic                      s1_last, s1_inside;
  logic [REG_W-1:0]          s1_row;

  logic                      out_valid;
  lpr_pix_t                  out_pix;

  logic [CMP_W-1:0]          x_u, y_u;
  logic                      in_bounds;
  logic [REG_W-1:0]          row;
  logic [2*REG_W-1:0]        prod;
  logic [SUM_W-1:0]          sum;
  logic                      s2_load;

  always_comb begin
    x_u       = CMP_W'($unsigned(cur.x));
    y_u       = CMP_W'($unsigned(cur.y));
    in_bounds = !cur.x[COORD_W-1] && !cur.y[COORD_W-1] &&
                (x_u < CMP_W'(frame_width)) && (y_u < CMP_W'(frame_height));
    // vertical flip; only meaningful when in bounds
    row    = frame_height - REG_W'(1) - REG_W'($unsigned(cur.y));
    prod   = s1_row * frame_width;
    sum    = SUM_W'(prod) + SUM_W'(REG_W'($unsigned(s1_x)));
  end

  assign s2_load = !out_valid || !pix_stall;
  assign hold    = s1_valid && !s2_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!hold) begin
      s1_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !hold) begin
      s1_x      <= cur.x;
      s1_y      <= cur.y;
      s1_last   <= cur.last;
      s1_inside <= in_bounds;
      s1_row    <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      out_pix.pixel_x       <= s1_x;
      out_pix.pixel_y       <= s1_y;
      out_pix.in_frame      <= s1_inside;
      out_pix.pixel_address <= s1_inside ? ADDR_W'(sum) : '0;
      out_pix.last_pixel    <= s1_last;
    end
  end

  assign pix_valid = out_valid;
  assign pix       = out_pix;

endmodule
`default_nettype wire

// ===== rtl/core/line_pixel_rasterizer_unit.sv =====
`default_nettype none
// A tick item's pixel is registered in stage 1 of the pipe, then in its output register.
// Throughput: one item per cycle while cmd_stall is low; an accepted tick steps a line short of its end.
// The cursor update (compare plus add) and the 12x12 address multiply set the pace.
// Reset (rst, synchronous, active high) drops any line, empties the pipeline and
// sets the frame to 1280 x 720.
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_unit: Bresenham line stepper with framebuffer address
// Line commands load endpoints; each tick on an active line emits the current pixel and steps.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  lpr_pkg::lpr_cmd_t             cmd,
  output logic                          pix_valid,
  input  logic                          pix_stall,
  output lpr_pkg::lpr_pix_t             pix,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lpr_pkg::APB_AW-1:0]    paddr,
  input  logic [lpr_pkg::APB_DW-1:0]    pwdata,
  output logic [lpr_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import lpr_pkg::*;

  localparam int REG_SEL_BIT = 2;  // 4-byte register spacing

  logic [REG_W-1:0] frame_width, frame_height;
  logic             cfg_wr, reg_idx;
  logic             cmd_acc, line_load, tick, push, active, hold;
  lpr_cursor_t      cur;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[REG_SEL_BIT];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width  <= pwdata[REG_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height);
      default:          prdata = '0;
    endcase
  end

  assign cmd_stall = hold;
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign line_load = cmd_acc && (cmd.action == ACT_LINE);
  assign tick      = cmd_acc && (cmd.action == ACT_TICK);
  assign push      = tick && active;

  lpr_stepper u_stepper (
    .clk    (clk),
    .rst    (rst),
    .load   (line_load),
    .step   (tick),
    .cmd    (cmd),
    .active (active),
    .cur    (cur)
  );

  lpr_pipe u_pipe (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .cur          (cur),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pix_stall    (pix_stall),
    .hold         (hold),
    .pix_valid    (pix_valid),
    .pix          (pix)
  );

  // the end point retires the line
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    push && cur.last |=> !active)
    else $error("line still active after last pixel");

  // input side stalls only behind a stalled full output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> pix_valid && pix_stall)
    else $error("command stalled without output back-pressure");

  a_offframe_addr: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix.in_frame |-> pix.pixel_address == '0)
    else $error("nonzero address for off-frame pixel");

  a_inframe_coords: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix.in_frame |-> !pix.pixel_x[COORD_W-1] && !pix.pixel_y[COORD_W-1])
    else $error("negative coordinate flagged in frame");

endmodule
`default_nettype wire

// ===== tb/lpr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_checker: pixel predictor and scoreboard for the line pixel rasterizer
// Follows register writes and accepted command items, steps its own Bresenham
// line state and compares every pixel item from the block, field by field.
// ----------------------------------------------------------------------------
module lpr_checker
  import lpr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  logic               cmd_stall,
  input  lpr_cmd_t           cmd,
  input  logic               pix_valid,
  input  logic               pix_stall,
  input  lpr_pix_t           pix,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);

  logic [REG_W-1:0]          frame_w;
  logic [REG_W-1:0]          frame_h;
  logic                      line_on;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] goal_x;
  logic signed [COORD_W-1:0] goal_y;
  logic [COORD_W-1:0]        run_x;
  logic [COORD_W-1:0]        run_y;
  logic                      step_x_neg;
  logic                      step_y_neg;
  logic signed [ERR_W-1:0]   bres_err;
  lpr_pix_t                  expected_pixels[$];

  // Returns 1 and the pixel when the item emits one.
  function automatic bit rasterize(input lpr_cmd_t c, output lpr_pix_t p);
    int     x0, y0, x1, y1;
    int     x, y, w, h, e, e2;
    longint row;
    p = '0;
    if (c.action == ACT_LINE) begin
      x0 = $signed(c.start_x);
      y0 = $signed(c.start_y);
      x1 = $signed(c.end_x);
      y1 = $signed(c.end_y);
      run_x      = COORD_W'((x1 > x0) ? x1 - x0 : x0 - x1);
      run_y      = COORD_W'((y1 > y0) ? y1 - y0 : y0 - y1);
      step_x_neg = !(x0 < x1);
      step_y_neg = !(y0 < y1);
      bres_err   = ERR_W'(int'(run_x) - int'(run_y));
      pos_x      = c.start_x;
      pos_y      = c.start_y;
      goal_x     = c.end_x;
      goal_y     = c.end_y;
      line_on    = 1'b1;
      return 1'b0;
    end
    if (!line_on)
      return 1'b0;

    x = pos_x;
    y = pos_y;
    w = int'(frame_w);
    h = int'(frame_h);
    p.pixel_x    = pos_x;
    p.pixel_y    = pos_y;
    p.in_frame   = (x >= 0) && (y >= 0) && (x < w) && (y < h);
    p.last_pixel = (pos_x == goal_x) && (pos_y == goal_y);
    if (p.in_frame) begin
      row = longint'(h - 1 - y);
      p.pixel_address = ADDR_W'(row * w + x);
    end

    if (p.last_pixel) begin
      line_on = 1'b0;
    end else begin
      e  = bres_err;
      e2 = 2 * e;
      if (e2 > -int'(run_y)) begin
        e     = e - int'(run_y);
        pos_x = step_x_neg ? pos_x - 1 : pos_x + 1;
      end
      if (e2 < int'(run_x)) begin
        e     = e + int'(run_x);
        pos_y = step_y_neg ? pos_y - 1 : pos_y + 1;
      end
      bres_err = ERR_W'(e);
    end
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    lpr_pix_t want;
    lpr_pix_t next_pix;
    if (rst) begin
      frame_w    = FRAME_WIDTH_RST;
      frame_h    = FRAME_HEIGHT_RST;
      line_on    = 1'b0;
      pos_x      = '0;
      pos_y      = '0;
      goal_x     = '0;
      goal_y     = '0;
      run_x      = '0;
      run_y      = '0;
      step_x_neg = 1'b0;
      step_y_neg = 1'b0;
      bres_err   = '0;
      expected_pixels.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[APB_AW-1:2] == REG_FRAME_WIDTH)
          frame_w = pwdata[REG_W-1:0];
        else if (paddr[APB_AW-1:2] == REG_FRAME_HEIGHT)
          frame_h = pwdata[REG_W-1:0];
      end

      if (pix_valid && !pix_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel item: x %0d y %0d", pix.pixel_x, pix.pixel_y);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_x", want.pixel_x, pix.pixel_x);
          check_field("pixel_y", want.pixel_y, pix.pixel_y);
          check_field("in_frame", want.in_frame, pix.in_frame);
          check_field("pixel_address", want.pixel_address, pix.pixel_address);
          check_field("last_pixel", want.last_pixel, pix.last_pixel);
        end
      end

      if (cmd_valid && !cmd_stall) begin
        if (rasterize(cmd, next_pix))
          expected_pixels = {expected_pixels, next_pix};
      end
    end
    pending = expected_pixels.size();
  end

endmodule

// ===== tb/line_pixel_rasterizer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_pixel_rasterizer_unit_tb: stimulus and verdict for the rasterizer
// Directed lines hit the coordinate extremes, single points, idle ticks and
// replaced lines; random lines follow under several frame sizes and idle mixes.
// ----------------------------------------------------------------------------
module line_pixel_rasterizer_unit_tb;
  import lpr_pkg::*;

  localparam int COORD_MIN       = -(1 << (COORD_W - 1));
  localparam int COORD_MAX       = (1 << (COORD_W - 1)) - 1;
  localparam int ITEMS_PER_PHASE = 60;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cmd_valid = 1'b0;
  logic              cmd_stall;
  lpr_cmd_t          cmd       = '0;
  logic              pix_valid;
  logic              pix_stall = 1'b0;
  lpr_pix_t          pix;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [APB_AW-1:0] paddr     = '0;
  logic [APB_DW-1:0] pwdata    = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;

  int send_gap_pct = 0;
  int stall_pct    = 0;
  int cur_w        = 1280;
  int cur_h        = 720;

  always #4 clk = ~clk;

  line_pixel_rasterizer_unit u_top (.*);

  lpr_checker u_checker (.*);

  always @(posedge clk) begin
    pix_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic int clamp_coord(input int v);
    return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  // mostly near the frame, sometimes anywhere in the coordinate range
  function automatic int pick_coord(input int lim);
    if ($urandom_range(9) < 3)
      return int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
    return clamp_coord(int'($urandom_range(lim + 16)) - 8);
  endfunction

  task automatic push_cmd(input lpr_cmd_t c);
    while ($urandom_range(99) < send_gap_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic send_line(input int x0, input int y0, input int x1, input int y1);
    lpr_cmd_t c;
    c.action  = ACT_LINE;
    c.start_x = COORD_W'(x0);
    c.start_y = COORD_W'(y0);
    c.end_x   = COORD_W'(x1);
    c.end_y   = COORD_W'(y1);
    push_cmd(c);
  endtask

  // endpoint fields of a tick are ignored, so they carry noise
  task automatic send_ticks(input int n);
    logic [63:0] noise;
    lpr_cmd_t    c;
    repeat (n) begin
      noise    = {$urandom(), $urandom()};
      c        = noise[$bits(lpr_cmd_t)-1:0];
      c.action = ACT_TICK;
      push_cmd(c);
    end
  endtask

  // a line command gives no pixel, so idle clocks follow once nothing is pending
  task automatic drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic idx, input int value);
    logic [APB_DW-1:0] data;
    data             = $urandom();
    data[REG_W-1:0]  = REG_W'(value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_frame(input int w, input int h);
    drain();
    apb_write(REG_FRAME_WIDTH, w);
    apb_write(REG_FRAME_HEIGHT, h);
    cur_w = w;
    cur_h = h;
  endtask

  task automatic run_random(input int quota);
    int made, kind, reach, span, ticks;
    int x0, y0, x1, y1;
    made = 0;
    while (made < quota) begin
      kind  = $urandom_range(99);
      reach = ($urandom_range(24) == 0) ? 300 : 10;
      x0    = pick_coord(cur_w);
      y0    = pick_coord(cur_h);
      x1    = clamp_coord(x0 + int'($urandom_range(2 * reach)) - reach);
      y1    = clamp_coord(y0 + int'($urandom_range(2 * reach)) - reach);
      span  = ((x1 > x0) ? x1 - x0 : x0 - x1);
      if (((y1 > y0) ? y1 - y0 : y0 - y1) > span)
        span = (y1 > y0) ? y1 - y0 : y0 - y1;
      span = span + 1;
      if (kind < 80) begin
        // full line, now and then a tick or two past its end
        ticks = span + (($urandom_range(4) == 0) ? int'($urandom_range(1, 2)) : 0);
      end else if (kind < 92) begin
        // cut short, the next command replaces it
        ticks = $urandom_range(span - 1);
      end else begin
        x0    = int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
        y0    = int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
        x1    = int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
        y1    = int'($urandom_range(COORD_MAX - COORD_MIN)) + COORD_MIN;
        ticks = $urandom_range(3);
      end
      send_line(x0, y0, x1, y1);
      send_ticks(ticks);
      made += 1 + ticks;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct = 8;
    stall_pct    = 74;
    send_ticks(1);
    send_line(5, 5, 5, 5);
    send_ticks(2);
    send_line(0, 0, 3, 1);
    send_ticks(4);
    send_line(1279, 719, 1281, 718);
    send_ticks(3);
    send_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    send_ticks(2);
    send_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_ticks(1);
    send_line(-1, -1, -3, 2);
    send_ticks(4);

    set_frame(64, 48);
    run_random(ITEMS_PER_PHASE);
    set_frame(1, 1);
    run_random(ITEMS_PER_PHASE);
    // frame at the top of the register range; the address wraps at ADDR_W bits
    set_frame(4095, 4095);
    run_random(ITEMS_PER_PHASE);

    send_gap_pct = 74;
    stall_pct    = 8;
    set_frame(0, 7);
    run_random(ITEMS_PER_PHASE);
    set_frame(2048, 2048);
    run_random(ITEMS_PER_PHASE);
    set_frame(33, 0);
    run_random(ITEMS_PER_PHASE);

    send_gap_pct = 0;
    stall_pct    = 0;
    set_frame(int'($urandom_range(1, 200)), int'($urandom_range(1, 200)));
    run_random(ITEMS_PER_PHASE);
    set_frame(1280, 720);
    run_random(ITEMS_PER_PHASE);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== line_pixel_rasterizer_unit.f =====
rtl/core/lpr_pkg.sv
rtl/core/lpr_stepper.sv
rtl/core/lpr_pipe.sv
rtl/core/line_pixel_rasterizer_unit.sv
tb/lpr_checker.sv
tb/line_pixel_rasterizer_unit_tb.sv
